// ===== sv/dpt_pkg.sv =====
// Package for the primality tester: widths, range limits, base table and
// the controller/datapath command and status structs. No dependencies.
package dpt_pkg;
    localparam int unsigned NW = 49;
    localparam int unsigned CW = 6;
    localparam int unsigned BASE_COUNT = 7;
    localparam logic [NW-1:0] RANGE_LOW  = 49'd17;
    localparam logic [NW-1:0] RANGE_HIGH = 49'd341550071728321;

    function automatic logic [4:0] base_at(input logic [2:0] k);
        logic [4:0] b;
        case (k)
            3'd0:    b = 5'd2;
            3'd1:    b = 5'd3;
            3'd2:    b = 5'd5;
            3'd3:    b = 5'd7;
            3'd4:    b = 5'd11;
            3'd5:    b = 5'd13;
            default: b = 5'd17;
        endcase
        return b;
    endfunction

    typedef enum logic [2:0] {
        OP_NONE, OP_LOAD, OP_BASE, OP_MUL_RB, OP_SQ_B, OP_SQ_X, OP_SHIFT_E
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] base_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic e_zero;
        logic e_lsb;
        logic x_one;
        logic x_nm1;
        logic is_even;
        logic in_range;
    } dp_stat_t;
endpackage

// ===== sv/deterministic_primality_test.sv =====
// Miller-Rabin primality test, bases 2..17, for 17 < n < 341550071728321.
// Result: for out-of-range or even n, set by the range and parity check that follows the load;
// otherwise after the per-base exponentiation and squaring loop of bit-serial modular products.
// Throughput: one item at a time; next item accepted after result is taken.
// Reset: asynchronous active-low rst_n clears the controller; no result pending.
module deterministic_primality_test (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // [48:0] candidate
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // [0] is_prime, [1] out_of_range
);
    dpt_pkg::dp_cmd_t  cmd;
    dpt_pkg::dp_stat_t stat;
    logic [5:0]        s_count;
    logic              p, o;
    logic              unused;

    assign unused  = ^s_tdata[55:49];
    assign m_tdata = {6'd0, o, p};

    dpt_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .candidate(s_tdata[48:0]),
        .cmd(cmd), .stat(stat), .s_count(s_count)
    );

    dpt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid & s_tready), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .is_prime(p), .out_of_range(o),
        .cmd(cmd), .stat(stat), .s_count(s_count)
    );
endmodule

// ===== sv/dpt_datapath.sv =====
// Datapath: operand registers and a bit-serial shift-and-add modular
// multiplier, one bit of the multiplier operand per cycle. Uses dpt_pkg.
module dpt_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dpt_pkg::NW-1:0]     candidate,
    input  dpt_pkg::dp_cmd_t           cmd,
    output dpt_pkg::dp_stat_t          stat,
    output logic [5:0]                 s_count
);
    logic [dpt_pkg::NW-1:0] n_reg, e_reg, b_reg, x_reg;
    logic [dpt_pkg::NW-1:0] mx_reg, my_reg;
    logic [dpt_pkg::NW:0]   acc_reg;
    logic [dpt_pkg::CW-1:0] cnt_reg;
    logic                   busy_reg, done_reg;
    logic [1:0]             dst_reg;
    logic [5:0]             s_reg;
    logic [dpt_pkg::NW:0]   a1, a2, a3, a4;
    logic [dpt_pkg::NW-1:0] nm1;
    logic [5:0]             tz;

    assign nm1 = n_reg - 1'b1;
    assign a1 = {acc_reg[dpt_pkg::NW-1:0], 1'b0};
    assign a2 = (a1 >= {1'b0, n_reg}) ? a1 - {1'b0, n_reg} : a1;
    assign a3 = my_reg[dpt_pkg::NW-1] ? a2 + {1'b0, mx_reg} : a2;
    assign a4 = (a3 >= {1'b0, n_reg}) ? a3 - {1'b0, n_reg} : a3;

    // lowest set bit above bit 0: trailing zeros of n-1 for odd n
    always_comb
    begin
        tz = 6'd0;
        for (int i = dpt_pkg::NW - 1; i >= 1; i--)
        begin
            if (candidate[i])
            begin
                tz = 6'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (cmd.op == dpt_pkg::OP_MUL_RB || cmd.op == dpt_pkg::OP_SQ_B
                     || cmd.op == dpt_pkg::OP_SQ_X)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= dpt_pkg::CW'(dpt_pkg::NW - 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            acc_reg <= a4;
            my_reg  <= {my_reg[dpt_pkg::NW-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                case (dst_reg)
                    2'd1:    b_reg <= a4[dpt_pkg::NW-1:0];
                    default: x_reg <= a4[dpt_pkg::NW-1:0];
                endcase
            end
        end
        else
        begin
            case (cmd.op)
                dpt_pkg::OP_LOAD:
                begin
                    n_reg <= candidate;
                    s_reg <= tz;
                end
                dpt_pkg::OP_BASE:
                begin
                    b_reg <= dpt_pkg::NW'(dpt_pkg::base_at(cmd.base_idx));
                    x_reg <= dpt_pkg::NW'(1);
                    e_reg <= (n_reg - 1'b1) >> s_reg;
                end
                dpt_pkg::OP_MUL_RB:
                begin
                    mx_reg <= x_reg; my_reg <= b_reg; acc_reg <= '0; dst_reg <= 2'd0;
                end
                dpt_pkg::OP_SQ_B:
                begin
                    mx_reg <= b_reg; my_reg <= b_reg; acc_reg <= '0; dst_reg <= 2'd1;
                end
                dpt_pkg::OP_SQ_X:
                begin
                    mx_reg <= x_reg; my_reg <= x_reg; acc_reg <= '0; dst_reg <= 2'd0;
                end
                dpt_pkg::OP_SHIFT_E: e_reg <= e_reg >> 1;
                default: ;
            endcase
        end
    end

    assign stat.mul_done = done_reg;
    assign stat.e_zero   = (e_reg == '0);
    assign stat.e_lsb    = e_reg[0];
    assign stat.x_one    = (x_reg == dpt_pkg::NW'(1));
    assign stat.x_nm1    = (x_reg == nm1);
    assign stat.is_even  = ~n_reg[0];
    assign stat.in_range = (n_reg > dpt_pkg::RANGE_LOW) && (n_reg < dpt_pkg::RANGE_HIGH);
    assign s_count       = s_reg;
endmodule

// ===== sv/dpt_ctrl.sv =====
// Controller: sequences load, per-base exponentiation and squaring loop,
// and holds the result register. Uses dpt_pkg.
module dpt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               is_prime,
    output logic               out_of_range,
    output dpt_pkg::dp_cmd_t   cmd,
    input  dpt_pkg::dp_stat_t  stat,
    input  logic [5:0]         s_count
);
    localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_BASE = 4'd2, S_EXP = 4'd3,
                           S_MRB = 4'd4, S_WRB = 4'd5, S_SQB = 4'd6, S_WSQB = 4'd7,
                           S_TEST = 4'd8, S_SQX = 4'd9, S_WSQX = 4'd10, S_OUT = 4'd11,
                           S_LOAD = 4'd12, S_STEP = 4'd13;
    logic [3:0] state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [5:0] i_reg, i_next;
    logic       p_reg, p_next, o_reg, o_next;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_OUT);
    assign is_prime     = p_reg;
    assign out_of_range = o_reg;

    always_comb
    begin
        state_next = state_reg; k_next = k_reg; i_next = i_reg;
        p_next = p_reg; o_next = o_reg; cmd.op = dpt_pkg::OP_NONE;
        cmd.base_idx = k_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire)
            begin
                cmd.op = dpt_pkg::OP_LOAD; state_next = S_CHK;
            end
            S_CHK:
            begin
                k_next = '0;
                if (!stat.in_range)
                begin
                    p_next = 1'b0; o_next = 1'b1; state_next = S_OUT;
                end
                else if (stat.is_even)
                begin
                    p_next = 1'b0; o_next = 1'b0; state_next = S_OUT;
                end
                else
                begin
                    p_next = 1'b1; o_next = 1'b0; state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                cmd.op = dpt_pkg::OP_BASE; state_next = S_EXP;
            end
            S_EXP:
                if (stat.e_zero) state_next = S_TEST;
                else if (stat.e_lsb)
                begin
                    cmd.op = dpt_pkg::OP_MUL_RB; state_next = S_WRB;
                end
                else state_next = S_SQB;
            S_WRB: if (stat.mul_done) state_next = S_SQB;
            S_SQB:
            begin
                cmd.op = dpt_pkg::OP_SQ_B; state_next = S_WSQB;
            end
            S_WSQB: if (stat.mul_done)
            begin
                state_next = S_MRB;
            end
            S_MRB:
            begin
                cmd.op = dpt_pkg::OP_SHIFT_E; state_next = S_EXP;
            end
            S_TEST:
            begin
                i_next = 6'd1;
                if (stat.x_one || stat.x_nm1) state_next = S_LOAD;
                else if (s_count > 6'd1) state_next = S_SQX;
                else
                begin
                    p_next = 1'b0; state_next = S_OUT;
                end
            end
            S_SQX:
            begin
                cmd.op = dpt_pkg::OP_SQ_X; state_next = S_WSQX;
            end
            S_WSQX: if (stat.mul_done)
            begin
                i_next = i_reg + 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (stat.x_nm1) state_next = S_LOAD;
                else if (i_reg < s_count) state_next = S_SQX;
                else
                begin
                    p_next = 1'b0; state_next = S_OUT;
                end
            end
            S_LOAD:
                if (k_reg == 3'(dpt_pkg::BASE_COUNT - 1)) state_next = S_OUT;
                else
                begin
                    k_next = k_reg + 1'b1; state_next = S_BASE;
                end
            S_OUT: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; k_reg <= '0; i_reg <= '0; p_reg <= 1'b0; o_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; k_reg <= k_next; i_reg <= i_next;
            p_reg <= p_next; o_reg <= o_next;
        end
    end
endmodule
